[hdl/cpsd_pkg.sv]
// shared types and constants for the cart-pole state derivative pipeline
package cpsd_pkg;

    typedef struct packed {
        logic signed [31:0] cart_velocity;
        logic signed [31:0] angle;
        logic signed [31:0] angular_velocity;
        logic signed [31:0] force_req;
    } cpsd_in_t;

    typedef struct packed {
        logic signed [31:0] position_rate;
        logic signed [31:0] cart_acceleration;
        logic signed [31:0] angle_rate;
        logic signed [31:0] angular_acceleration;
        logic               fault;
    } cpsd_out_t;

    // quotient width and magnitude bits produced by the divider
    localparam int Q_W     = 48;
    localparam int QBITS   = 43;
    localparam int REM_W   = 22;
    localparam int DIV_LAT = QBITS + 2;

    typedef struct packed {
        logic signed [Q_W-1:0] quo;
        logic                  flt;
    } cpsd_quo_t;

    localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
    localparam logic signed [31:0] INV2PI_Q32 = 32'sd683565276;
    localparam logic signed [33:0] PI_Q30     = 34'sd3373259426;
    localparam logic signed [31:0] B_Q16      = 32'sd956826;
    localparam logic signed [31:0] ML_Q16     = 32'sd574095;
    localparam logic signed [31:0] MM_Q16     = 32'sd1435238;
    localparam logic signed [31:0] G_Q16      = 32'sd642908;
    localparam logic signed [31:0] K_Q16      = 32'sd2296381;
    localparam logic signed [31:0] HML_Q30    = 32'sd1666996;
    localparam logic signed [31:0] MN1_Q30    = 32'sd49029307;
    localparam logic signed [Q_W-1:0] QLIM    = 48'sd140737488355327;
    localparam logic signed [63:0] NLIM       = 64'sd70368744177664;

    // exact reciprocals ceil(2^(30+l)/d) for operands below 2^30
    localparam logic signed [31:0] RCP42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
    localparam logic signed [31:0] RCP20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
    localparam logic signed [31:0] RCP6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
    localparam logic signed [31:0] RCP56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
    localparam logic signed [31:0] RCP30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
    localparam logic signed [31:0] RCP12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);

endpackage

[hdl/cpsd_mul.sv]
// two-stage signed multiplier giving floor(a*b / 2^SH)
module cpsd_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 16,
    parameter int OW = 32
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [OW-1:0] p
);
    logic signed [AW-17:0]    a_hi;
    logic        [15:0]       a_lo;
    logic signed [AW-16+BW-1:0] ph_reg;
    logic signed [16+BW:0]    pl_reg;
    logic signed [AW+BW:0]    sum;
    logic signed [AW+BW:0]    shr;
    logic signed [OW-1:0]     p_reg;

    assign a_hi = a[AW-1:16];
    assign a_lo = a[15:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg <= a_hi * b;
            pl_reg <= $signed({1'b0, a_lo}) * b;
        end
    end

    assign sum = ((AW+BW+1)'(ph_reg) <<< 16) + (AW+BW+1)'(pl_reg);
    assign shr = sum >>> SH;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= shr[OW-1:0];
        end
    end

    assign p = p_reg;
endmodule

[hdl/cpsd_div.sv]
// pipelined restoring divider, one quotient bit per stage, truncating toward zero
module cpsd_div (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [63:0]  num,
    input  logic signed [31:0]  den,
    output cpsd_pkg::cpsd_quo_t res
);
    import cpsd_pkg::*;

    logic [63:0]       n_abs;
    logic [31:0]       d_abs;
    logic              dz;
    logic              huge;
    logic              n_pos;
    logic              d_pos;

    logic [REM_W-1:0]  rem_reg [QBITS+1];
    logic [QBITS-1:0]  dvd_reg [QBITS+1];
    logic [QBITS-1:0]  quo_reg [QBITS+1];
    logic [REM_W-1:0]  dm_reg  [QBITS+1];
    logic [QBITS:0]    sgn_reg;
    logic [QBITS:0]    spc_reg;
    logic [QBITS:0]    spn_reg;

    logic [REM_W:0]    trial [QBITS];
    logic [REM_W:0]    nrem  [QBITS];
    logic [QBITS-1:0]  ge;

    logic signed [Q_W-1:0] mag;
    cpsd_quo_t             res_reg;

    assign n_abs = num[63] ? 64'(-num) : 64'(num);
    assign d_abs = den[31] ? 32'(-den) : 32'(den);
    assign dz    = (den == 32'sd0);
    assign huge  = (num >= NLIM) || (num <= -NLIM);
    assign n_pos = (num > 64'sd0);
    assign d_pos = (den > 32'sd0);

    always_comb begin
        for (int i = 0; i < QBITS; i++) begin
            trial[i] = {rem_reg[i], dvd_reg[i][QBITS-1]};
            ge[i]    = (trial[i] >= {1'b0, dm_reg[i]});
            nrem[i]  = ge[i] ? (trial[i] - {1'b0, dm_reg[i]}) : trial[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // top bits of the shifted dividend already lie below the divisor
            rem_reg[0] <= REM_W'(n_abs[45:27]);
            dvd_reg[0] <= {n_abs[26:0], 16'd0};
            quo_reg[0] <= '0;
            dm_reg[0]  <= d_abs[REM_W-1:0];
            sgn_reg[0] <= num[63] ^ den[31];
            spc_reg[0] <= dz || huge;
            spn_reg[0] <= dz ? num[63] : (n_pos != d_pos);
            for (int i = 0; i < QBITS; i++) begin
                rem_reg[i+1] <= nrem[i][REM_W-1:0];
                dvd_reg[i+1] <= {dvd_reg[i][QBITS-2:0], 1'b0};
                quo_reg[i+1] <= {quo_reg[i][QBITS-2:0], ge[i]};
                dm_reg[i+1]  <= dm_reg[i];
                sgn_reg[i+1] <= sgn_reg[i];
                spc_reg[i+1] <= spc_reg[i];
                spn_reg[i+1] <= spn_reg[i];
            end
        end
    end

    assign mag = $signed(Q_W'(quo_reg[QBITS]));

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.flt <= spc_reg[QBITS];
            if (spc_reg[QBITS]) begin
                res_reg.quo <= spn_reg[QBITS] ? -QLIM : QLIM;
            end else begin
                res_reg.quo <= sgn_reg[QBITS] ? -mag : mag;
            end
        end
    end

    assign res = res_reg;
endmodule

[hdl/cart_pole_state_derivative.sv]
// cart-pole state derivative: 76-stage fixed-point pipeline, one word per cycle while the skid entry is empty
// an accepted word steps through every stage in order; all stages stall together while the skid entry is full
// the two 43-stage quotient dividers set the depth
// a two-entry output (register plus skid) lets one more word in while a result waits
// reset (aresetn low, synchronous) empties every stage and the output; no other state
module cart_pole_state_derivative (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cpsd_pkg::cpsd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cpsd_pkg::cpsd_out_t m_data
);
    import cpsd_pkg::*;

    localparam int LAST = 75;

    logic            en;
    logic [LAST:0]   vld_reg;
    cpsd_in_t        in_reg;

    // delay lines, element j of a line sits one stage after element j-1
    logic signed [31:0] v_dly   [75];
    logic signed [31:0] w_dly   [75];
    logic signed [31:0] f_dly   [2];
    logic signed [40:0] ub_dly  [17];
    logic        [1:0]  kq_dly  [16];
    logic signed [47:0] kub_dly [22];
    logic signed [31:0] hw_dly  [19];
    logic signed [31:0] x_dly   [12];
    logic signed [31:0] x2_dly  [10];
    logic signed [31:0] c_dly   [4];
    logic signed [31:0] mlc_dly [2];
    logic signed [31:0] den_dly [5];
    logic signed [47:0] cub_dly [6];
    logic signed [39:0] rr_dly  [4];
    logic signed [39:0] mlcr_dly[2];
    logic               fc_dly  [56];
    cpsd_quo_t          qth_dly [2];
    logic               fx_dly  [2];

    logic signed [31:0] ph_k2, hw_k2, x_k4, x2_k6;
    logic signed [39:0] vb_k2;
    logic signed [40:0] ub_k2;
    logic        [31:0] ph_sum, ru;
    logic        [1:0]  kq_k2;
    logic signed [47:0] kub_k5;
    logic signed [31:0] qs1, qc1, ts1, tc1, ps1, pc1;
    logic signed [31:0] qs2, qc2, ts2, tc2, ps2, pc2;
    logic signed [31:0] qs3, qc3, ts3, tc3, s0_k18, pc3;
    logic signed [31:0] c0_k18, s_rot, c_rot;
    logic signed [31:0] s_k19_reg, c_k19_reg;
    logic               fc_k19_reg;
    logic signed [31:0] mls_k21, mlc_k21, gs_k21, den1_k23, den_k23;
    logic signed [47:0] cub_k21;
    logic signed [32:0] gmh_k21;
    logic signed [39:0] mlsw_k23, rr_k23, cp1_k25, mlcr_k25;
    logic signed [47:0] kp1_k25;
    logic signed [55:0] cp_k27;
    logic signed [63:0] kp_k27;
    logic signed [63:0] nth_k28_reg, nx_k28_reg;
    cpsd_quo_t          qth_k73, qx_k73;
    logic signed [47:0] xdd_k75;

    logic signed [47:0] qth_fin;
    logic               th_hi, th_lo, x_hi, x_lo;
    cpsd_out_t          fin_word;
    logic               take;

    cpsd_out_t          out_reg, skid_reg;
    logic               m_valid_reg, skid_v_reg;

    assign en      = !skid_v_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;
        end
    end

    // early products that need no sine or cosine
    cpsd_mul #(.AW(32), .BW(32), .SH(16), .OW(32)) u_ph (
        .aclk(aclk), .en(en), .a(in_reg.angle), .b(INV2PI_Q32), .p(ph_k2));
    cpsd_mul #(.AW(32), .BW(32), .SH(16), .OW(40)) u_vb (
        .aclk(aclk), .en(en), .a(in_reg.cart_velocity), .b(B_Q16), .p(vb_k2));
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_hw (
        .aclk(aclk), .en(en), .a(in_reg.angular_velocity), .b(HML_Q30), .p(hw_k2));

    assign ub_k2  = 41'(f_dly[1]) - 41'(vb_k2);
    // nearest quarter turn and the remainder within it
    assign ph_sum = ph_k2 + 32'h2000_0000;
    assign kq_k2  = ph_sum[31:30];
    assign ru     = ph_k2 - {kq_k2, 30'd0};

    cpsd_mul #(.AW(32), .BW(34), .SH(31), .OW(32)) u_x (
        .aclk(aclk), .en(en), .a($signed(ru)), .b(PI_Q30), .p(x_k4));
    cpsd_mul #(.AW(41), .BW(32), .SH(16), .OW(48)) u_kub (
        .aclk(aclk), .en(en), .a(ub_dly[0]), .b(K_Q16), .p(kub_k5));
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_x2 (
        .aclk(aclk), .en(en), .a(x_k4), .b(x_k4), .p(x2_k6));

    // horner chains for sine and cosine
    cpsd_mul #(.AW(32), .BW(32), .SH(36), .OW(32)) u_qs1 (
        .aclk(aclk), .en(en), .a(x2_k6), .b(RCP42), .p(qs1));
    cpsd_mul #(.AW(32), .BW(32), .SH(36), .OW(32)) u_qc1 (
        .aclk(aclk), .en(en), .a(x2_k6), .b(RCP56), .p(qc1));
    assign ts1 = ONE_Q30 - qs1;
    assign tc1 = ONE_Q30 - qc1;
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_ps1 (
        .aclk(aclk), .en(en), .a(x2_dly[1]), .b(ts1), .p(ps1));
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_pc1 (
        .aclk(aclk), .en(en), .a(x2_dly[1]), .b(tc1), .p(pc1));
    cpsd_mul #(.AW(32), .BW(32), .SH(35), .OW(32)) u_qs2 (
        .aclk(aclk), .en(en), .a(ps1), .b(RCP20), .p(qs2));
    cpsd_mul #(.AW(32), .BW(32), .SH(35), .OW(32)) u_qc2 (
        .aclk(aclk), .en(en), .a(pc1), .b(RCP30), .p(qc2));
    assign ts2 = ONE_Q30 - qs2;
    assign tc2 = ONE_Q30 - qc2;
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_ps2 (
        .aclk(aclk), .en(en), .a(x2_dly[5]), .b(ts2), .p(ps2));
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_pc2 (
        .aclk(aclk), .en(en), .a(x2_dly[5]), .b(tc2), .p(pc2));
    cpsd_mul #(.AW(32), .BW(32), .SH(33), .OW(32)) u_qs3 (
        .aclk(aclk), .en(en), .a(ps2), .b(RCP6), .p(qs3));
    cpsd_mul #(.AW(32), .BW(32), .SH(34), .OW(32)) u_qc3 (
        .aclk(aclk), .en(en), .a(pc2), .b(RCP12), .p(qc3));
    assign ts3 = ONE_Q30 - qs3;
    assign tc3 = ONE_Q30 - qc3;
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_s0 (
        .aclk(aclk), .en(en), .a(x_dly[11]), .b(ts3), .p(s0_k18));
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_pc3 (
        .aclk(aclk), .en(en), .a(x2_dly[9]), .b(tc3), .p(pc3));

    assign c0_k18 = ONE_Q30 - (pc3 >>> 1);

    always_comb begin
        unique case (kq_dly[15])
            2'd0: begin s_rot = s0_k18;  c_rot = c0_k18;  end
            2'd1: begin s_rot = c0_k18;  c_rot = -s0_k18; end
            2'd2: begin s_rot = -s0_k18; c_rot = -c0_k18; end
            default: begin s_rot = -c0_k18; c_rot = s0_k18; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_k19_reg  <= s_rot;
            c_k19_reg  <= c_rot;
            fc_k19_reg <= (c_rot == 32'sd0);
        end
    end

    // dynamics terms
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_mls (
        .aclk(aclk), .en(en), .a(s_k19_reg), .b(ML_Q16), .p(mls_k21));
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_mlc (
        .aclk(aclk), .en(en), .a(c_k19_reg), .b(ML_Q16), .p(mlc_k21));
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_gs (
        .aclk(aclk), .en(en), .a(s_k19_reg), .b(G_Q16), .p(gs_k21));
    cpsd_mul #(.AW(41), .BW(32), .SH(30), .OW(48)) u_cub (
        .aclk(aclk), .en(en), .a(ub_dly[16]), .b(c_k19_reg), .p(cub_k21));

    assign gmh_k21 = 33'(gs_k21) - 33'(hw_dly[18]);

    cpsd_mul #(.AW(32), .BW(32), .SH(16), .OW(40)) u_mlsw (
        .aclk(aclk), .en(en), .a(w_dly[20]), .b(mls_k21), .p(mlsw_k23));
    cpsd_mul #(.AW(33), .BW(32), .SH(16), .OW(40)) u_rr (
        .aclk(aclk), .en(en), .a(gmh_k21), .b(MM_Q16), .p(rr_k23));
    cpsd_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_den (
        .aclk(aclk), .en(en), .a(mlc_k21), .b(c_dly[1]), .p(den1_k23));

    assign den_k23 = den1_k23 - K_Q16;

    cpsd_mul #(.AW(40), .BW(32), .SH(30), .OW(40)) u_cp1 (
        .aclk(aclk), .en(en), .a(mlsw_k23), .b(c_dly[3]), .p(cp1_k25));
    cpsd_mul #(.AW(40), .BW(32), .SH(16), .OW(48)) u_kp1 (
        .aclk(aclk), .en(en), .a(mlsw_k23), .b(K_Q16), .p(kp1_k25));
    cpsd_mul #(.AW(40), .BW(32), .SH(16), .OW(40)) u_mlcr (
        .aclk(aclk), .en(en), .a(rr_k23), .b(mlc_dly[1]), .p(mlcr_k25));
    cpsd_mul #(.AW(40), .BW(32), .SH(16), .OW(56)) u_cp (
        .aclk(aclk), .en(en), .a(cp1_k25), .b(w_dly[24]), .p(cp_k27));
    cpsd_mul #(.AW(48), .BW(32), .SH(16), .OW(64)) u_kp (
        .aclk(aclk), .en(en), .a(kp1_k25), .b(w_dly[24]), .p(kp_k27));

    always_ff @(posedge aclk) begin
        if (en) begin
            nth_k28_reg <= 64'(cub_dly[5]) + 64'(cp_k27) - 64'(rr_dly[3]);
            nx_k28_reg  <= 64'(mlcr_dly[1]) - 64'(kub_dly[21]) - kp_k27;
        end
    end

    cpsd_div u_div_th (
        .aclk(aclk), .en(en), .num(nth_k28_reg), .den(den_dly[4]), .res(qth_k73));
    cpsd_div u_div_x (
        .aclk(aclk), .en(en), .num(nx_k28_reg), .den(den_dly[4]), .res(qx_k73));

    cpsd_mul #(.AW(48), .BW(32), .SH(30), .OW(48)) u_xdd (
        .aclk(aclk), .en(en), .a(qx_k73.quo), .b(MN1_Q30), .p(xdd_k75));

    always_ff @(posedge aclk) begin
        if (en) begin
            v_dly[0]    <= in_reg.cart_velocity;
            w_dly[0]    <= in_reg.angular_velocity;
            f_dly[0]    <= in_reg.force_req;
            f_dly[1]    <= f_dly[0];
            ub_dly[0]   <= ub_k2;
            kq_dly[0]   <= kq_k2;
            hw_dly[0]   <= hw_k2;
            kub_dly[0]  <= kub_k5;
            x_dly[0]    <= x_k4;
            x2_dly[0]   <= x2_k6;
            c_dly[0]    <= c_k19_reg;
            mlc_dly[0]  <= mlc_k21;
            den_dly[0]  <= den_k23;
            cub_dly[0]  <= cub_k21;
            rr_dly[0]   <= rr_k23;
            mlcr_dly[0] <= mlcr_k25;
            fc_dly[0]   <= fc_k19_reg;
            qth_dly[0]  <= qth_k73;
            qth_dly[1]  <= qth_dly[0];
            fx_dly[0]   <= qx_k73.flt;
            fx_dly[1]   <= fx_dly[0];
            for (int i = 1; i < 75; i++) begin
                v_dly[i] <= v_dly[i-1];
                w_dly[i] <= w_dly[i-1];
            end
            for (int i = 1; i < 17; i++) ub_dly[i]   <= ub_dly[i-1];
            for (int i = 1; i < 16; i++) kq_dly[i]   <= kq_dly[i-1];
            for (int i = 1; i < 19; i++) hw_dly[i]   <= hw_dly[i-1];
            for (int i = 1; i < 22; i++) kub_dly[i]  <= kub_dly[i-1];
            for (int i = 1; i < 12; i++) x_dly[i]    <= x_dly[i-1];
            for (int i = 1; i < 10; i++) x2_dly[i]   <= x2_dly[i-1];
            for (int i = 1; i < 4; i++)  c_dly[i]    <= c_dly[i-1];
            mlc_dly[1]  <= mlc_dly[0];
            for (int i = 1; i < 5; i++)  den_dly[i]  <= den_dly[i-1];
            for (int i = 1; i < 6; i++)  cub_dly[i]  <= cub_dly[i-1];
            for (int i = 1; i < 4; i++)  rr_dly[i]   <= rr_dly[i-1];
            mlcr_dly[1] <= mlcr_dly[0];
            for (int i = 1; i < 56; i++) fc_dly[i]   <= fc_dly[i-1];
        end
    end

    // clamp both accelerations to 32 bits
    assign qth_fin = qth_dly[1].quo;
    assign th_hi   = (qth_fin > 48'sd2147483647);
    assign th_lo   = (qth_fin < -48'sd2147483648);
    assign x_hi    = (xdd_k75 > 48'sd2147483647);
    assign x_lo    = (xdd_k75 < -48'sd2147483648);

    always_comb begin
        fin_word.position_rate = v_dly[74];
        fin_word.angle_rate    = w_dly[74];
        priority if (th_hi) begin
            fin_word.angular_acceleration = 32'sh7fff_ffff;
        end else if (th_lo) begin
            fin_word.angular_acceleration = 32'sh8000_0000;
        end else begin
            fin_word.angular_acceleration = qth_fin[31:0];
        end
        priority if (x_hi) begin
            fin_word.cart_acceleration = 32'sh7fff_ffff;
        end else if (x_lo) begin
            fin_word.cart_acceleration = 32'sh8000_0000;
        end else begin
            fin_word.cart_acceleration = xdd_k75[31:0];
        end
        fin_word.fault = fc_dly[55] | qth_dly[1].flt | fx_dly[1]
                       | th_hi | th_lo | x_hi | x_lo;
    end

    // last stage is consumed only on the edge at which it advances
    assign take = en && vld_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_v_reg) begin
                m_valid_reg <= 1'b1;
                skid_v_reg  <= 1'b0;
            end else begin
                m_valid_reg <= take;
            end
        end else if (take) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_v_reg) begin
                out_reg <= skid_reg;
            end else if (take) begin
                out_reg <= fin_word;
            end
        end else if (take) begin
            skid_reg <= fin_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
endmodule

[hdl/cpsd_checker.sv]
// port-level checks for the cart-pole derivative block and their bind
module cpsd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input cpsd_pkg::cpsd_out_t m_data
);
    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result word changed while stalled");

    // reset empties the output
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // reset leaves the input open
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // input closes only after the output was held back
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!m_valid || m_ready) |-> s_ready)
        else $error("input stalled without an output stall");
endmodule

bind cart_pole_state_derivative cpsd_checker u_cpsd_checker (.*);
